// File: src/cbm_pkg.sv
package cbm_pkg;

	// Mapper kind codes
	localparam logic [3:0] KIND_NONE    = 4'd0;
	localparam logic [3:0] KIND_MBC1    = 4'd1;
	localparam logic [3:0] KIND_MBC2    = 4'd2;
	localparam logic [3:0] KIND_MBC5    = 4'd4;
	localparam logic [3:0] KIND_MMM01   = 4'd7;
	localparam logic [3:0] KIND_MBC1_HU = 4'd8;

	// Configuration register indexes
	localparam logic [1:0] REG_MAPPER_KIND      = 2'd0;
	localparam logic [1:0] REG_MULTICART_LAYOUT = 2'd1;
	localparam logic [1:0] REG_ROM_BANK_TOTAL   = 2'd2;
	localparam logic [1:0] REG_RAM_BANK_TOTAL   = 2'd3;

	// Width of the raw ROM bank (base plus offset reaches 1022)
	localparam int unsigned RAW_W = 10;
	// One cell per dividend bit
	localparam int unsigned CELL_COUNT = RAW_W;
	localparam int unsigned RAM_REM_W = 5;

	typedef struct packed {
		logic       lower_window;
		logic [4:0] low_bank_bits;
		logic [1:0] high_bank_bits;
		logic       ram_banking_mode;
		logic [8:0] selected_rom_bank;
		logic [8:0] wide_rom_bank;
		logic       base_locked;
		logic [8:0] mmm01_base;
		logic [3:0] selected_ram_bank;
	} cbm_in_t;

	typedef struct packed {
		logic [8:0] rom_bank;
		logic [3:0] ram_bank;
	} cbm_out_t;

	// Partial remainders and dividend bits still to shift in
	typedef struct packed {
		logic [RAW_W-1:0]     rom_rem;
		logic [RAW_W-1:0]     rom_div;
		logic [RAM_REM_W-1:0] ram_rem;
		logic [RAW_W-1:0]     ram_div;
	} cbm_lane_t;

endpackage

// File: src/cartridge_bank_mapper.sv
// Ten registered cells, one per raw bank bit, lie between the accepting edge and result valid.
// Throughput: one item per cycle while result_stall is low; each remainder cell holds one item.
// The chain length is set by the 10-bit raw bank that feeds the restoring modulo.
// Reset: valid flags clear, config returns to kind none, normal layout, two ROM
// banks, no RAM. Payload registers are not reset.
module cartridge_bank_mapper #(
	parameter int unsigned ROM_BANK_LIMIT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  cbm_pkg::cbm_in_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output cbm_pkg::cbm_out_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import cbm_pkg::*;

	localparam logic [RAW_W-1:0] LIMIT_W = RAW_W'(ROM_BANK_LIMIT);

	logic [3:0]           mapper_kind_q;
	logic                 multicart_layout_q;
	logic [RAW_W-1:0]     rom_total_q;
	logic [RAM_REM_W-1:0] ram_total_q;
	logic [RAW_W-1:0]     rom_div_by;
	logic [1:0]           reg_idx;

	cbm_lane_t            first_lane;
	cbm_lane_t            lane [CELL_COUNT+1];
	logic                 vld  [CELL_COUNT+1];
	logic                 go   [CELL_COUNT+1];

	// Configuration port: always ready, write on the access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind_q      <= KIND_NONE;
			multicart_layout_q <= 1'b0;
			rom_total_q        <= RAW_W'(2);
			ram_total_q        <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MAPPER_KIND:      mapper_kind_q      <= pwdata[3:0];
				REG_MULTICART_LAYOUT: multicart_layout_q <= pwdata[0];
				REG_ROM_BANK_TOTAL:   rom_total_q        <= pwdata[RAW_W-1:0];
				REG_RAM_BANK_TOTAL:   ram_total_q        <= pwdata[RAM_REM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAPPER_KIND:      prdata = {28'd0, mapper_kind_q};
			REG_MULTICART_LAYOUT: prdata = {31'd0, multicart_layout_q};
			REG_ROM_BANK_TOTAL:   prdata = {{(32-RAW_W){1'b0}}, rom_total_q};
			REG_RAM_BANK_TOTAL:   prdata = {{(32-RAM_REM_W){1'b0}}, ram_total_q};
			default:              prdata = '0;
		endcase
	end

	// Clamp the bank count to the supported limit before the reduction
	assign rom_div_by = (rom_total_q > LIMIT_W) ? LIMIT_W : rom_total_q;

	// Raw bank selection feeds the first cell directly
	cbm_bank_map u_map (
		.item             (item),
		.mapper_kind      (mapper_kind_q),
		.multicart_layout (multicart_layout_q),
		.lane             (first_lane)
	);

	assign lane[0] = first_lane;
	assign vld[0]  = item_valid;

	// A cell loads when it is empty or its successor moves on; the last one
	// moves on when the result is taken. Bubbles collapse, so an item is
	// accepted while a finished result still waits.
	assign go[CELL_COUNT] = !result_stall;

	genvar k;
	generate
		for (k = 0; k < CELL_COUNT; k++) begin : g_cell
			assign go[k] = !vld[k+1] || go[k+1];

			cbm_mod_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.load       (go[k]),
				.valid_in   (vld[k]),
				.lane_in    (lane[k]),
				.rom_div_by (rom_div_by),
				.ram_div_by (ram_total_q),
				.valid_out  (vld[k+1]),
				.lane_out   (lane[k+1])
			);
		end
	endgenerate

	assign item_stall   = !go[0];
	assign result_valid = vld[CELL_COUNT];

	// Zero counts force a zero bank; the remainder is meaningless then
	always_comb begin
		result.rom_bank = (rom_total_q == '0) ? 9'd0 : lane[CELL_COUNT].rom_rem[8:0];
		result.ram_bank = (ram_total_q == '0) ? 4'd0 : lane[CELL_COUNT].ram_rem[3:0];
	end

endmodule

// File: src/cbm_bank_map.sv
module cbm_bank_map (
	input  cbm_pkg::cbm_in_t   item,
	input  logic [3:0]         mapper_kind,
	input  logic               multicart_layout,
	output cbm_pkg::cbm_lane_t lane
);
	import cbm_pkg::*;

	logic [4:0]       low_fix;
	logic [3:0]       mbc2_bank;
	logic [8:0]       mmm_off;
	logic [RAW_W-1:0] raw;
	logic [3:0]       ram_div;
	logic             mbc1_like;

	always_comb begin
		low_fix   = (item.low_bank_bits == 5'd0) ? 5'd1 : item.low_bank_bits;
		mbc2_bank = (item.selected_rom_bank[3:0] == 4'd0) ? 4'd1 : item.selected_rom_bank[3:0];
		mmm_off   = (item.selected_rom_bank == 9'd0) ? 9'd1 : item.selected_rom_bank;
		mbc1_like = (mapper_kind == KIND_MBC1) || (mapper_kind == KIND_MBC1_HU);
		raw       = '0;
		case (mapper_kind)
			KIND_NONE: begin
				raw = item.lower_window ? 10'd0 : 10'd1;
			end
			KIND_MBC1, KIND_MBC1_HU: begin
				if (multicart_layout) begin
					if (item.lower_window)
						raw = item.ram_banking_mode ? {4'd0, item.high_bank_bits, 4'd0} : 10'd0;
					else
						raw = {4'd0, item.high_bank_bits, item.low_bank_bits[3:0]};
				end else begin
					if (item.lower_window)
						raw = item.ram_banking_mode ? {3'd0, item.high_bank_bits, 5'd0} : 10'd0;
					else
						raw = {3'd0, item.high_bank_bits, low_fix};
				end
			end
			KIND_MBC2: begin
				raw = item.lower_window ? 10'd0 : {6'd0, mbc2_bank};
			end
			KIND_MBC5: begin
				raw = item.lower_window ? 10'd0 : {1'b0, item.wide_rom_bank};
			end
			KIND_MMM01: begin
				if (!item.base_locked)
					raw = item.lower_window ? 10'd0 : {1'b0, item.selected_rom_bank};
				else if (item.lower_window)
					raw = {1'b0, item.mmm01_base};
				else
					raw = {1'b0, item.mmm01_base} + {1'b0, mmm_off};
			end
			default: begin
				raw = item.lower_window ? 10'd0 : {1'b0, item.selected_rom_bank};
			end
		endcase

		// For MBC1 kinds, banking mode 0 pins the RAM bank to zero
		if (mbc1_like)
			ram_div = item.ram_banking_mode ? {2'd0, item.high_bank_bits} : 4'd0;
		else
			ram_div = item.selected_ram_bank;

		lane.rom_rem = '0;
		lane.rom_div = raw;
		lane.ram_rem = '0;
		lane.ram_div = {{(RAW_W-4){1'b0}}, ram_div};
	end

endmodule

// File: src/cbm_mod_cell.sv
module cbm_mod_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  valid_in,
	input  cbm_pkg::cbm_lane_t    lane_in,
	input  logic [cbm_pkg::RAW_W-1:0]     rom_div_by,
	input  logic [cbm_pkg::RAM_REM_W-1:0] ram_div_by,
	output logic                  valid_out,
	output cbm_pkg::cbm_lane_t    lane_out
);
	import cbm_pkg::*;

	logic [RAW_W:0]     rom_try;
	logic [RAM_REM_W:0] ram_try;
	cbm_lane_t          nxt;

	// One restoring step on each lane: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rom_try = {lane_in.rom_rem, lane_in.rom_div[RAW_W-1]};
		if (rom_try >= {1'b0, rom_div_by})
			rom_try = rom_try - {1'b0, rom_div_by};
		ram_try = {lane_in.ram_rem, lane_in.ram_div[RAW_W-1]};
		if (ram_try >= {1'b0, ram_div_by})
			ram_try = ram_try - {1'b0, ram_div_by};
		nxt.rom_rem = rom_try[RAW_W-1:0];
		nxt.rom_div = {lane_in.rom_div[RAW_W-2:0], 1'b0};
		nxt.ram_rem = ram_try[RAM_REM_W-1:0];
		nxt.ram_div = {lane_in.ram_div[RAW_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_out <= 1'b0;
		else if (load)
			valid_out <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (load)
			lane_out <= nxt;
	end

endmodule

// File: sim/tb_cartridge_bank_mapper.sv
module tb_cartridge_bank_mapper;
	import cbm_pkg::*;

	localparam int unsigned ROM_LIMIT    = 512;
	// Cycles with no accepted item on either side before the run is abandoned
	localparam int unsigned STALL_LIMIT  = 2000;
	// Latency of the block plus margin, for stray results after the last one due
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PRINT_CAP    = 40;
	localparam int unsigned BURSTS       = 12;
	localparam int unsigned BURST_ITEMS  = 51;

	// Kinds that the package leaves unnamed but the block still serves
	localparam logic [3:0] KIND_MBC3  = 4'd3;
	localparam logic [3:0] KIND_UNDEF = 4'd15;

	// Scoreboard: shadow of the mapper registers and the queue of banks due
	class bank_ledger;
		logic [3:0]  kind;
		logic        multicart;
		logic [9:0]  rom_total;
		logic [4:0]  ram_total;
		cbm_out_t    due_banks[$];
		int unsigned errors;

		function new();
			kind      = KIND_NONE;
			multicart = 1'b0;
			rom_total = 10'd2;
			ram_total = 5'd0;
			errors    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_MAPPER_KIND:      kind      = v[3:0];
				REG_MULTICART_LAYOUT: multicart = v[0];
				REG_ROM_BANK_TOTAL:   rom_total = v[9:0];
				REG_RAM_BANK_TOTAL:   ram_total = v[4:0];
				default: ;
			endcase
		endfunction

		// Work out the ROM and RAM bank that the current kind selects
		function cbm_out_t map_banks(cbm_in_t a);
			int unsigned raw;
			int unsigned low;
			int unsigned nudge;
			int unsigned span;
			int unsigned ram;
			cbm_out_t    r;
			low = a.low_bank_bits;
			case (kind)
				KIND_NONE: raw = a.lower_window ? 0 : 1;
				KIND_MBC1, KIND_MBC1_HU: begin
					if (multicart) begin
						// four-bit low bank, upper bits at bit 4, no promotion
						if (a.lower_window)
							raw = a.ram_banking_mode ? (a.high_bank_bits << 4) : 0;
						else
							raw = (a.high_bank_bits << 4) | (low & 'hf);
					end else begin
						if (low == 0)
							low = 1;
						if (a.lower_window)
							raw = a.ram_banking_mode ? (a.high_bank_bits << 5) : 0;
						else
							raw = low | (a.high_bank_bits << 5);
					end
				end
				KIND_MBC2: begin
					raw = a.selected_rom_bank[3:0];
					if (raw == 0)
						raw = 1;
					if (a.lower_window)
						raw = 0;
				end
				KIND_MBC5: raw = a.lower_window ? 0 : a.wide_rom_bank;
				KIND_MMM01: begin
					if (!a.base_locked) begin
						raw = a.lower_window ? 0 : a.selected_rom_bank;
					end else begin
						// keep the full sum, up to 1022, before the reduction
						nudge = (a.selected_rom_bank == 0) ? 1 : a.selected_rom_bank;
						raw = a.lower_window ? a.mmm01_base : a.mmm01_base + nudge;
					end
				end
				default: raw = a.lower_window ? 0 : a.selected_rom_bank;
			endcase

			// Saturate an oversized bank count, zero count maps to bank 0
			span = (rom_total > ROM_LIMIT) ? ROM_LIMIT : rom_total;
			r.rom_bank = (span == 0) ? 9'd0 : 9'(raw % span);

			ram = 0;
			if (ram_total != 0) begin
				if (kind == KIND_MBC1 || kind == KIND_MBC1_HU) begin
					if (a.ram_banking_mode)
						ram = a.high_bank_bits % ram_total;
				end else begin
					ram = a.selected_ram_bank % ram_total;
				end
			end
			r.ram_bank = 4'(ram);
			return r;
		endfunction

		function void log_access(cbm_in_t a);
			due_banks.push_back(map_banks(a));
		endfunction

		task flag(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_banks(cbm_out_t got);
			cbm_out_t want;
			if (due_banks.size() == 0) begin
				flag($sformatf("unexpected item rom_bank=%0d ram_bank=%0d",
					got.rom_bank, got.ram_bank));
			end else begin
				want = due_banks.pop_front();
				if (got.rom_bank !== want.rom_bank)
					flag($sformatf("rom_bank got %0d want %0d", got.rom_bank, want.rom_bank));
				if (got.ram_bank !== want.ram_bank)
					flag($sformatf("ram_bank got %0d want %0d", got.ram_bank, want.ram_bank));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	cbm_in_t     item;
	logic        result_valid;
	logic        result_stall;
	cbm_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned send_gap_pct;
	int unsigned recv_gap_pct;
	int unsigned quiet_cycles = 0;
	bank_ledger  book = new();

	cartridge_bank_mapper #(
		.ROM_BANK_LIMIT(ROM_LIMIT)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at the rate of the current phase
	always @(posedge clk) begin
		result_stall <= arst_n && ($urandom_range(0, 99) < recv_gap_pct);
	end

	// Sample at the falling edge: handshake signals are settled until the next rising
	// edge, so what is seen here is what that edge accepts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				book.check_banks(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offer one item, idling first at the sender rate; returns in the step of the
	// accepting edge with valid still high so a back-to-back item never toggles it.
	task automatic send_item(input cbm_in_t a);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= a;
		item_valid <= 1'b1;
		@(negedge clk);
		while (item_stall)
			@(negedge clk);
		book.log_access(a);
		@(posedge clk);
	endtask

	task automatic send_fields(input logic lw, input logic [4:0] lo, input logic [1:0] hi,
		input logic md, input logic [8:0] sel, input logic [8:0] wd, input logic lk,
		input logic [8:0] bs, input logic [3:0] rs);
		cbm_in_t a;
		a = '{lw, lo, hi, md, sel, wd, lk, bs, rs};
		send_item(a);
	endtask

	// Setup cycle then access cycle; the register takes the value at the edge that
	// sees psel, penable and pready together.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		book.set_reg(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_drained();
		while (book.due_banks.size() != 0)
			@(posedge clk);
	endtask

	// Drop valid, let every item in flight come out, then reprogram all registers
	task automatic apply_setup(input logic [3:0] kind, input logic layout,
		input logic [9:0] rom, input logic [4:0] ram);
		item_valid <= 1'b0;
		wait_drained();
		write_reg(REG_MAPPER_KIND, {28'd0, kind});
		write_reg(REG_MULTICART_LAYOUT, {31'd0, layout});
		write_reg(REG_ROM_BANK_TOTAL, {22'd0, rom});
		write_reg(REG_RAM_BANK_TOTAL, {27'd0, ram});
	endtask

	// Lean toward both ends of a field
	function automatic int unsigned skew(input int unsigned top);
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return top;
		return $urandom_range(0, top);
	endfunction

	function automatic cbm_in_t random_access();
		cbm_in_t a;
		a.lower_window      = 1'($urandom_range(0, 1));
		a.low_bank_bits     = 5'(skew(31));
		a.high_bank_bits    = 2'($urandom_range(0, 3));
		a.ram_banking_mode  = 1'($urandom_range(0, 1));
		a.selected_rom_bank = 9'(skew(511));
		a.wide_rom_bank     = 9'(skew(511));
		a.base_locked       = 1'($urandom_range(0, 1));
		a.mmm01_base        = 9'(skew(511));
		a.selected_ram_bank = 4'(skew(15));
		return a;
	endfunction

	task automatic random_setup();
		logic [3:0] kind;
		logic [9:0] rom;
		logic [4:0] ram;
		case ($urandom_range(0, 9))
			0, 1:    kind = 4'($urandom_range(0, 15));
			2, 3:    kind = KIND_MBC1;
			4:       kind = KIND_MBC1_HU;
			5:       kind = KIND_MBC2;
			6:       kind = KIND_MBC5;
			7, 8:    kind = KIND_MMM01;
			default: kind = KIND_NONE;
		endcase
		case ($urandom_range(0, 9))
			0:       rom = 10'd0;
			1:       rom = 10'd1;
			2:       rom = 10'd2;
			3:       rom = 10'd72;
			4:       rom = 10'd80;
			5:       rom = 10'd96;
			6:       rom = 10'd512;
			7:       rom = 10'd1023;
			default: rom = 10'($urandom_range(1, 1023));
		endcase
		case ($urandom_range(0, 7))
			0:       ram = 5'd0;
			1:       ram = 5'd1;
			2:       ram = 5'd16;
			3:       ram = 5'd31;
			default: ram = 5'($urandom_range(0, 31));
		endcase
		apply_setup(kind, 1'($urandom_range(0, 1)), rom, ram);
	endtask

	initial begin
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		send_gap_pct = 19;
		recv_gap_pct = 82;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setup: no mapper, two banks, no RAM
		send_fields(1, 31, 3, 1, 511, 511, 1, 511, 15);
		send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);

		// Normal wiring, bank count of 72: low bank zero promoted, both modes, both windows
		apply_setup(KIND_MBC1, 1'b0, 10'd72, 5'd4);
		send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_fields(0, 31, 3, 0, 0, 0, 0, 0, 0);
		send_fields(1, 31, 3, 1, 0, 0, 0, 0, 0);
		send_fields(1, 5, 2, 0, 0, 0, 0, 0, 0);
		send_fields(0, 16, 1, 1, 0, 0, 0, 0, 0);

		// Multicart wiring, count above the limit, RAM count above sixteen
		apply_setup(KIND_MBC1, 1'b1, 10'd1023, 5'd31);
		send_fields(0, 31, 3, 0, 0, 0, 0, 0, 0);
		send_fields(1, 0, 3, 1, 0, 0, 0, 0, 0);
		send_fields(0, 0, 0, 1, 0, 0, 0, 0, 0);

		// Four-bit bank: zero nibble promoted, lower window fixed
		apply_setup(KIND_MBC2, 1'b0, 10'd16, 5'd16);
		send_fields(0, 0, 0, 0, 9'h1f0, 0, 0, 0, 15);
		send_fields(1, 0, 0, 0, 9'h1ff, 0, 0, 0, 0);
		send_fields(0, 0, 0, 0, 9'h00a, 0, 0, 0, 9);

		// Zero ROM count maps everything to bank 0
		apply_setup(KIND_MBC5, 1'b0, 10'd0, 5'd0);
		send_fields(0, 0, 0, 0, 0, 511, 0, 0, 15);

		apply_setup(KIND_MBC5, 1'b0, 10'd512, 5'd1);
		send_fields(0, 0, 0, 0, 0, 511, 0, 0, 15);
		send_fields(1, 0, 0, 0, 0, 511, 0, 0, 0);

		// Locked base plus offset at full width, unlocked pass-through
		apply_setup(KIND_MMM01, 1'b0, 10'd512, 5'd3);
		send_fields(0, 0, 0, 0, 0, 0, 0, 0, 15);
		send_fields(0, 0, 0, 0, 511, 0, 1, 511, 14);
		send_fields(1, 0, 0, 0, 511, 0, 1, 511, 0);
		send_fields(0, 0, 0, 0, 0, 0, 1, 5, 7);

		apply_setup(KIND_MBC1_HU, 1'b0, 10'd80, 5'd2);
		send_fields(0, 0, 3, 1, 0, 0, 0, 0, 0);

		// Undefined kind behaves as pass-through
		apply_setup(KIND_UNDEF, 1'b0, 10'd96, 5'd5);
		send_fields(0, 0, 0, 0, 511, 0, 0, 0, 14);
		send_fields(1, 0, 0, 0, 511, 0, 0, 0, 14);

		// Count just above the limit
		apply_setup(KIND_MBC3, 1'b0, 10'd513, 5'd17);
		send_fields(0, 0, 0, 0, 300, 0, 0, 0, 15);

		// Random bursts: slow receiver, then slow sender, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 19 : (phase == 1) ? 82 : 0;
			recv_gap_pct = (phase == 0) ? 82 : (phase == 1) ? 19 : 0;
			for (int b = 0; b < BURSTS; b++) begin
				random_setup();
				for (int n = 0; n < BURST_ITEMS; n++)
					send_item(random_access());
			end
		end

		item_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
